/* hw/rtl/bfg_pkg.sv */
// Shared constants, field widths and lookup tables for the battery fuel gauge monitor.
package bfg_pkg;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_UV_MV    = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [14:0] CAPACITY_RST = 15'd3000;
	localparam logic [15:0] UV_MV_RST    = 16'd9600;
	localparam logic [15:0] DEBOUNCE_RST = 16'd1000;

	// Power state codes, in the order of their meaning.
	localparam logic [2:0] PS_UNKNOWN     = 3'd0;
	localparam logic [2:0] PS_IDLE        = 3'd1;
	localparam logic [2:0] PS_CHARGING    = 3'd2;
	localparam logic [2:0] PS_DISCHARGING = 3'd3;
	localparam logic [2:0] PS_OTG         = 3'd4;
	localparam logic [2:0] PS_UNDERVOLT   = 3'd5;
	localparam logic [2:0] PS_FAULT       = 3'd6;

	localparam int SOC_POINTS = 11;
	localparam int IN_BYTES   = 9;
	localparam int OUT_BYTES  = 7;
	localparam int DIV_W      = 32;
	localparam int DIVISOR_W  = 25;

	localparam logic [DIVISOR_W-1:0] MS_PER_HOUR = 25'd3600;
	localparam logic [DIVISOR_W-1:0] PCT_SCALE   = 25'd100;
	localparam logic [9:0]           UAH_PER_MAH = 10'd1000;

	// Voltage to state of charge breakpoints.
	localparam logic [15:0] SOC_MV [SOC_POINTS] = '{
		16'd9000, 16'd9600, 16'd9900, 16'd10500, 16'd10800, 16'd11100,
		16'd11400, 16'd11700, 16'd12000, 16'd12300, 16'd12600};
	localparam logic [6:0] SOC_PCT [SOC_POINTS] = '{
		7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40, 7'd55, 7'd70, 7'd85, 7'd95, 7'd100};

endpackage

/* hw/rtl/battery_fuel_gauge_monitor.sv */
// Battery fuel gauge monitor: coulomb counter with voltage seeding and undervoltage debounce.
//
// Usage: each poll tick enters as one transfer on the s_ channel and leaves one result
// transfer on the m_ channel. Configuration (capacity, undervoltage threshold, debounce
// time) is written through the APB port; the user must write it only while no tick is in
// flight, which the block itself does not enforce. pready is always high. A tick is
// decoded first, then each division runs through one shared restoring divider that
// produces one quotient bit per cycle. A tick with invalid ADC readings skips the divider;
// a seeded tick takes one division with zero elapsed time and two divisions otherwise;
// the first valid tick seeds the charge from the voltage table and takes up to four
// divisions. A zero capacity skips the percent division. One tick is in work at a time.
// The result waits in an output register, so the next tick is taken while the receiver
// stalls; that tick then holds in its final state until the output register frees up.
// Reset clears the remaining charge to minus one, the seed flag, the debounce time and the
// held percent, and loads the register defaults.
module battery_fuel_gauge_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] tick_ms, [16] device_present, [17] adc_valid, [33:18] vbat_mv,
	// [48:34] charge_ma, [63:49] discharge_ma, [64] charger_fault,
	// [65] charging_active, [66] otg_active, [67] comparator_high, [71:68] zero
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] power_state, [18:3] battery_current, [44:19] remaining_uah,
	// [51:45] charge_pct, [52] uv_seen, [53] undervoltage_confirmed,
	// [55:54] zero
	output logic [55:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_SEED1 = 4'd3;
	localparam logic [3:0] S_SEED2 = 4'd4;
	localparam logic [3:0] S_INT   = 4'd5;
	localparam logic [3:0] S_INT2  = 4'd6;
	localparam logic [3:0] S_PCT   = 4'd7;
	localparam logic [3:0] S_PCT2  = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	localparam int DW = bfg_pkg::DIV_W;
	localparam int VW = bfg_pkg::DIVISOR_W;

	logic [3:0]  state_q;
	logic [3:0]  div_next_q;
	logic [4:0]  div_cnt_q;
	logic [14:0] capacity_q;
	logic [15:0] uv_mv_q;
	logic [15:0] debounce_q;
	logic signed [25:0] remain_q;
	logic        seeded_q;
	logic [16:0] uv_time_q;
	logic [6:0]  percent_q;
	logic        m_tvalid_q;

	logic [15:0] elapsed_q;
	logic        present_q;
	logic        adc_valid_q;
	logic [15:0] mv_q;
	logic [14:0] chg_q;
	logic [14:0] dchg_q;
	logic        fault_q;
	logic        charging_q;
	logic        otg_q;
	logic        cmp_high_q;

	logic signed [15:0] current_q;
	logic        uv_raw_q;
	logic        uv_conf_q;
	logic [VW-1:0] cap1000_q;
	logic [6:0]  pbase_q;
	logic        neg_q;
	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dvs_q;
	logic [VW-1:0] part_q;
	logic [55:0] m_tdata_q;

	logic s_fire;
	logic cfg_wr;
	logic out_free;

	// Current, undervoltage and table segment decode.
	logic signed [15:0] current_d;
	logic        uv_raw_d;
	logic        uv_conf_d;
	logic [16:0] uv_time_d;
	logic [3:0]  seg;
	logic [6:0]  pbase_d;
	logic [9:0]  off_d;
	logic [3:0]  pspan_d;
	logic [9:0]  vspan_d;

	// Divider step and arithmetic of the other states.
	logic [VW:0]   trial_in;
	logic [VW:0]   trial;
	logic          q_bit;
	logic [6:0]    seed_pct;
	logic signed [31:0] charge_prod;
	logic [31:0]   charge_mag;
	logic signed [26:0] delta;
	logic signed [26:0] sum;
	logic [25:0]   clamped;
	logic [2:0]    pstate;

	assign s_fire   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !m_tvalid_q || m_tready;
	assign pready   = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		case (paddr[3:2])
			bfg_pkg::REG_CAPACITY: prdata = {17'd0, capacity_q};
			bfg_pkg::REG_UV_MV:    prdata = {16'd0, uv_mv_q};
			bfg_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_q};
			default:               prdata = 32'd0;
		endcase
	end

	always_comb begin
		current_d = 16'sd0;
		if (adc_valid_q) begin
			if (charging_q && chg_q != 15'd0) begin
				current_d = $signed({1'b0, chg_q});
			end else if (dchg_q != 15'd0) begin
				current_d = -$signed({1'b0, dchg_q});
			end
		end

		uv_raw_d = (present_q && !cmp_high_q) || (adc_valid_q && (mv_q <= uv_mv_q));
		if (uv_raw_d) begin
			uv_time_d = (uv_time_q < {1'b0, debounce_q}) ? uv_time_q + {1'b0, elapsed_q}
				: uv_time_q;
			uv_conf_d = (uv_time_d >= {1'b0, debounce_q});
		end else begin
			uv_time_d = 17'd0;
			uv_conf_d = 1'b0;
		end

		// Lowest breakpoint at or above the voltage.
		seg = 4'd10;
		for (int k = bfg_pkg::SOC_POINTS - 1; k >= 1; k--) begin
			if (mv_q <= bfg_pkg::SOC_MV[k]) begin
				seg = 4'(k);
			end
		end
		if (mv_q <= bfg_pkg::SOC_MV[0]) begin
			pbase_d = bfg_pkg::SOC_PCT[0];
			off_d   = 10'd0;
			pspan_d = 4'd0;
			vspan_d = 10'd1;
		end else if (mv_q > bfg_pkg::SOC_MV[bfg_pkg::SOC_POINTS-1]) begin
			pbase_d = bfg_pkg::SOC_PCT[bfg_pkg::SOC_POINTS-1];
			off_d   = 10'd0;
			pspan_d = 4'd0;
			vspan_d = 10'd1;
		end else begin
			pbase_d = bfg_pkg::SOC_PCT[seg - 4'd1];
			off_d   = 10'(mv_q - bfg_pkg::SOC_MV[seg - 4'd1]);
			pspan_d = 4'(bfg_pkg::SOC_PCT[seg] - bfg_pkg::SOC_PCT[seg - 4'd1]);
			vspan_d = 10'(bfg_pkg::SOC_MV[seg] - bfg_pkg::SOC_MV[seg - 4'd1]);
		end
	end

	always_comb begin
		trial_in = {part_q, dvd_q[DW-1]};
		trial    = trial_in - {1'b0, dvs_q};
		q_bit    = (trial_in >= {1'b0, dvs_q});

		seed_pct    = pbase_q + dvd_q[6:0];
		charge_prod = current_q * $signed({1'b0, elapsed_q});
		charge_mag  = charge_prod[31] ? 32'(-charge_prod) : 32'(charge_prod);

		// The integration quotient stays below 2^20.
		delta = neg_q ? -$signed({6'd0, dvd_q[20:0]}) : $signed({6'd0, dvd_q[20:0]});
		sum   = {remain_q[25], remain_q} + delta;
		if (sum < 27'sd0) begin
			clamped = 26'd0;
		end else if (sum > $signed({2'b00, cap1000_q})) begin
			clamped = {1'b0, cap1000_q};
		end else begin
			clamped = sum[25:0];
		end

		if (fault_q) begin
			pstate = bfg_pkg::PS_FAULT;
		end else if (uv_conf_q) begin
			pstate = bfg_pkg::PS_UNDERVOLT;
		end else if (otg_q) begin
			pstate = bfg_pkg::PS_OTG;
		end else if (charging_q) begin
			pstate = bfg_pkg::PS_CHARGING;
		end else if (current_q < 16'sd0) begin
			pstate = bfg_pkg::PS_DISCHARGING;
		end else if (present_q) begin
			pstate = bfg_pkg::PS_IDLE;
		end else begin
			pstate = bfg_pkg::PS_UNKNOWN;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			div_next_q <= S_IDLE;
			div_cnt_q  <= 5'd0;
			capacity_q <= bfg_pkg::CAPACITY_RST;
			uv_mv_q    <= bfg_pkg::UV_MV_RST;
			debounce_q <= bfg_pkg::DEBOUNCE_RST;
			remain_q   <= -26'sd1;
			seeded_q   <= 1'b0;
			uv_time_q  <= 17'd0;
			percent_q  <= 7'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					bfg_pkg::REG_CAPACITY: capacity_q <= pwdata[14:0];
					bfg_pkg::REG_UV_MV:    uv_mv_q    <= pwdata[15:0];
					bfg_pkg::REG_DEBOUNCE: debounce_q <= pwdata[15:0];
					default: ;
				endcase
			end
			// A new result may replace the one leaving in the same cycle.
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					uv_time_q <= uv_time_d;
					div_cnt_q <= 5'd0;
					if (!adc_valid_q) begin
						state_q <= S_FIN;
					end else if (!seeded_q) begin
						state_q    <= S_DIV;
						div_next_q <= S_SEED1;
					end else if (elapsed_q != 16'd0) begin
						state_q <= S_INT;
					end else begin
						state_q <= S_PCT;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(DW - 1)) begin
						state_q <= div_next_q;
					end
				end
				S_SEED1: begin
					state_q    <= S_DIV;
					div_next_q <= S_SEED2;
				end
				S_SEED2: begin
					remain_q <= $signed({1'b0, dvd_q[24:0]});
					seeded_q <= 1'b1;
					state_q  <= (elapsed_q != 16'd0) ? S_INT : S_PCT;
				end
				S_INT: begin
					state_q    <= S_DIV;
					div_next_q <= S_INT2;
				end
				S_INT2: begin
					remain_q <= $signed(clamped);
					state_q  <= S_PCT;
				end
				S_PCT: begin
					if (cap1000_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q    <= S_DIV;
						div_next_q <= S_PCT2;
					end
				end
				S_PCT2: begin
					percent_q <= dvd_q[6:0];
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: latched tick, serial divider and the output register.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			elapsed_q  <= s_tdata[15:0];
			present_q  <= s_tdata[16];
			adc_valid_q <= s_tdata[17];
			mv_q       <= s_tdata[33:18];
			chg_q      <= s_tdata[48:34];
			dchg_q     <= s_tdata[63:49];
			fault_q    <= s_tdata[64];
			charging_q <= s_tdata[65];
			otg_q      <= s_tdata[66];
			cmp_high_q <= s_tdata[67];
		end
		case (state_q)
			S_PREP: begin
				current_q <= current_d;
				uv_raw_q  <= uv_raw_d;
				uv_conf_q <= uv_conf_d;
				cap1000_q <= VW'({10'd0, capacity_q} * {15'd0, bfg_pkg::UAH_PER_MAH});
				pbase_q   <= pbase_d;
				dvd_q     <= {22'd0, off_d} * {28'd0, pspan_d};
				dvs_q     <= VW'(vspan_d);
				part_q    <= '0;
			end
			S_DIV: begin
				part_q <= q_bit ? trial[VW-1:0] : trial_in[VW-1:0];
				dvd_q  <= {dvd_q[DW-2:0], q_bit};
			end
			S_SEED1: begin
				dvd_q  <= {7'd0, cap1000_q} * {25'd0, seed_pct};
				dvs_q  <= bfg_pkg::PCT_SCALE;
				part_q <= '0;
			end
			S_INT: begin
				neg_q  <= charge_prod[31];
				dvd_q  <= charge_mag;
				dvs_q  <= bfg_pkg::MS_PER_HOUR;
				part_q <= '0;
			end
			S_PCT: begin
				dvd_q  <= DW'({7'd0, remain_q[24:0]} * 32'd100) + DW'(cap1000_q[VW-1:1]);
				dvs_q  <= cap1000_q;
				part_q <= '0;
			end
			S_FIN: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, uv_conf_q, uv_raw_q, percent_q, remain_q,
						current_q, pstate};
				end
			end
			default: ;
		endcase
	end

endmodule

/* sim/gauge_checker.sv */
// Checker that predicts each fuel gauge result from the accepted ticks and compares it.
module gauge_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [15:0] tick_ms, [16] device_present, [17] adc_valid, [33:18] vbat_mv,
	// [48:34] charge_ma, [63:49] discharge_ma, [64] charger_fault,
	// [65] charging_active, [66] otg_active, [67] comparator_high, [71:68] zero
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] power_state, [18:3] battery_current, [44:19] remaining_uah,
	// [51:45] charge_pct, [52] uv_seen, [53] undervoltage_confirmed,
	// [55:54] zero
	input  logic [55:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          failures,
	output int          pending,
	output int          checked,
	output int          clamp_hits,
	output int          uv_confirmations
);

	typedef struct packed {
		logic [3:0]  pad;
		logic        cmp_high;
		logic        otg;
		logic        charging;
		logic        fault;
		logic [14:0] dchg;
		logic [14:0] chg;
		logic [15:0] mv;
		logic        adc_valid;
		logic        present;
		logic [15:0] elapsed;
	} tick_t;

	typedef struct packed {
		logic [1:0]         pad;
		logic               uv_conf;
		logic               uv_raw;
		logic [6:0]         percent;
		logic signed [25:0] remaining;
		logic signed [15:0] current;
		logic [2:0]         state;
	} gauge_result_t;

	localparam longint MS_IN_HOUR    = 3600;
	localparam longint UAH_IN_MAH    = 1000;
	localparam longint PERCENT_SCALE = 100;
	localparam int     REPORT_LIMIT  = 10;

	// Voltage breakpoints and their state of charge, lowest point in element 0.
	localparam logic [10:0][15:0] SOC_MV_PT = {16'd12600, 16'd12300, 16'd12000, 16'd11700,
		16'd11400, 16'd11100, 16'd10800, 16'd10500, 16'd9900, 16'd9600, 16'd9000};
	localparam logic [10:0][6:0] SOC_PCT_PT = {7'd100, 7'd95, 7'd85, 7'd70, 7'd55, 7'd40,
		7'd30, 7'd20, 7'd10, 7'd5, 7'd0};

	logic [14:0]   capacity_mah;
	logic [15:0]   uv_threshold_mv;
	logic [15:0]   debounce_ms;
	longint        charge_uah;
	bit            seeded;
	int            uv_time_ms;
	logic [6:0]    percent_held;
	gauge_result_t expected_results[$];
	int            fail_count;
	int            check_count;
	int            clamp_count;
	int            confirm_count;

	function automatic int soc_percent(input logic [15:0] mv);
		int v;
		int k;
		int lo_mv;
		int hi_mv;
		int lo_pct;
		int hi_pct;
		v = int'(mv);
		lo_mv = int'(SOC_MV_PT[0]);
		if (v <= lo_mv)
			return int'(SOC_PCT_PT[0]);
		for (k = 1; k < 11; k++) begin
			lo_mv = int'(SOC_MV_PT[k-1]);
			hi_mv = int'(SOC_MV_PT[k]);
			lo_pct = int'(SOC_PCT_PT[k-1]);
			hi_pct = int'(SOC_PCT_PT[k]);
			if (v <= hi_mv)
				return lo_pct + (v - lo_mv) * (hi_pct - lo_pct) / (hi_mv - lo_mv);
		end
		return int'(SOC_PCT_PT[10]);
	endfunction

	task automatic advance_gauge(input tick_t t, output gauge_result_t r);
		longint cap_uah;
		longint level;
		int     current;
		bit     uv_raw;
		bit     uv_conf;
		cap_uah = longint'(capacity_mah) * UAH_IN_MAH;
		current = 0;
		uv_raw = 1'b0;
		uv_conf = 1'b0;
		if (t.adc_valid) begin
			if (t.charging && t.chg != 0)
				current = int'(t.chg);
			else if (t.dchg != 0)
				current = -int'(t.dchg);
			// The first valid tick seeds the charge from the voltage table.
			if (!seeded) begin
				charge_uah = cap_uah * soc_percent(t.mv) / PERCENT_SCALE;
				seeded = 1'b1;
			end
			if (t.elapsed != 0) begin
				level = charge_uah + longint'(current) * longint'(t.elapsed) / MS_IN_HOUR;
				if (level < 0 || level > cap_uah)
					clamp_count++;
				if (level < 0)
					level = 0;
				if (level > cap_uah)
					level = cap_uah;
				charge_uah = level;
			end
			if (cap_uah > 0) begin
				level = (charge_uah * PERCENT_SCALE + cap_uah / 2) / cap_uah;
				percent_held = level[6:0];
			end
		end
		if (t.present && !t.cmp_high)
			uv_raw = 1'b1;
		if (t.adc_valid && t.mv <= uv_threshold_mv)
			uv_raw = 1'b1;
		if (uv_raw) begin
			// Time stops accumulating once the debounce window has been reached.
			if (uv_time_ms < int'(debounce_ms))
				uv_time_ms += int'(t.elapsed);
			if (uv_time_ms >= int'(debounce_ms))
				uv_conf = 1'b1;
		end else begin
			uv_time_ms = 0;
		end
		r = '0;
		if (t.fault)
			r.state = bfg_pkg::PS_FAULT;
		else if (uv_conf)
			r.state = bfg_pkg::PS_UNDERVOLT;
		else if (t.otg)
			r.state = bfg_pkg::PS_OTG;
		else if (t.charging)
			r.state = bfg_pkg::PS_CHARGING;
		else if (current < 0)
			r.state = bfg_pkg::PS_DISCHARGING;
		else if (t.present)
			r.state = bfg_pkg::PS_IDLE;
		else
			r.state = bfg_pkg::PS_UNKNOWN;
		r.current = current[15:0];
		r.remaining = charge_uah[25:0];
		r.percent = percent_held;
		r.uv_raw = uv_raw;
		r.uv_conf = uv_conf;
		if (uv_conf)
			confirm_count++;
	endtask

	task automatic compare_field(input string name, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			if (fail_count < REPORT_LIMIT)
				$display("Mismatch in %s of result %0d: expected %0d, got %0d",
					name, check_count, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		gauge_result_t got;
		gauge_result_t want;
		if (!arst_n) begin
			capacity_mah = bfg_pkg::CAPACITY_RST;
			uv_threshold_mv = bfg_pkg::UV_MV_RST;
			debounce_ms = bfg_pkg::DEBOUNCE_RST;
			charge_uah = -1;
			seeded = 1'b0;
			uv_time_ms = 0;
			percent_held = '0;
			expected_results.delete();
			fail_count = 0;
			check_count = 0;
			clamp_count = 0;
			confirm_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				check_count++;
				if (expected_results.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("Result transfer %h arrived with no tick outstanding", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("power_state", want.state, got.state);
					compare_field("battery_current", want.current, got.current);
					compare_field("remaining_uah", want.remaining, got.remaining);
					compare_field("charge_pct", want.percent, got.percent);
					compare_field("uv_seen", want.uv_raw, got.uv_raw);
					compare_field("undervoltage_confirmed", want.uv_conf, got.uv_conf);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					bfg_pkg::REG_CAPACITY: capacity_mah = pwdata[14:0];
					bfg_pkg::REG_UV_MV:    uv_threshold_mv = pwdata[15:0];
					bfg_pkg::REG_DEBOUNCE: debounce_ms = pwdata[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				advance_gauge(s_tdata, want);
				expected_results.push_back(want);
			end
		end
		failures <= fail_count;
		pending <= expected_results.size();
		checked <= check_count;
		clamp_hits <= clamp_count;
		uv_confirmations <= confirm_count;
	end

endmodule

/* sim/testbench.sv */
// Top of the fuel gauge testbench: clock, reset, tick and register stimulus, and the verdict.
module testbench;

	localparam int RANDOM_PER_PHASE = 210;
	localparam int PHASES           = 8;
	localparam int IDLE_THIRD       = PHASES * RANDOM_PER_PHASE / 3;
	localparam int HOLD_OFF_CYCLES  = 400;
	localparam int STALL_LIMIT      = 4000;
	localparam int SETTLE_CYCLES    = 200;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [3:0]  pad;
		logic        cmp_high;
		logic        otg;
		logic        charging;
		logic        fault;
		logic [14:0] dchg;
		logic [14:0] chg;
		logic [15:0] mv;
		logic        adc_valid;
		logic        present;
		logic [15:0] elapsed;
	} tick_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [15:0] tick_ms, [16] device_present, [17] adc_valid, [33:18] vbat_mv,
	// [48:34] charge_ma, [63:49] discharge_ma, [64] charger_fault,
	// [65] charging_active, [66] otg_active, [67] comparator_high, [71:68] zero
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// [2:0] power_state, [18:3] battery_current, [44:19] remaining_uah,
	// [51:45] charge_pct, [52] uv_seen, [53] undervoltage_confirmed,
	// [55:54] zero
	logic [55:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          failures;
	int          pending;
	int          checked;
	int          clamp_hits;
	int          uv_confirmations;

	int          send_gap_pct;
	int          recv_stall_pct;
	bit          hold_off_now;
	bit          charge_trend;
	bit          uv_run;
	logic [15:0] uv_cfg;
	int          ticks_sent;
	int          random_sent;

	battery_fuel_gauge_monitor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	gauge_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.pready           (pready),
		.failures         (failures),
		.pending          (pending),
		.checked          (checked),
		.clamp_hits       (clamp_hits),
		.uv_confirmations (uv_confirmations)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver stalls at random; once per run it holds off long enough to back up the block.
	initial begin : receiver
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_now) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_now = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic tick_t make_tick(input logic [15:0] elapsed, input int present, adc,
			input logic [15:0] mv, input logic [14:0] chg, dchg,
			input int fault, charging, otg, cmp_high);
		tick_t t;
		t = '0;
		t.elapsed = elapsed;
		t.present = present[0];
		t.adc_valid = adc[0];
		t.mv = mv;
		t.chg = chg;
		t.dchg = dchg;
		t.fault = fault[0];
		t.charging = charging[0];
		t.otg = otg[0];
		t.cmp_high = cmp_high[0];
		return t;
	endfunction

	function automatic logic [14:0] random_ma();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return 15'd0;
		if (pick < 25)
			return 15'h7FFF;
		if (pick < 75)
			return 15'($urandom_range(3000));
		return 15'($urandom);
	endfunction

	// Mostly plausible poll ticks that follow the current charge and undervoltage trend.
	function automatic tick_t random_tick();
		tick_t t;
		int    pick;
		int    v;
		t = '0;
		if ($urandom_range(9) == 0) begin
			t.elapsed = 16'($urandom);
			t.present = 1'($urandom);
			t.adc_valid = 1'($urandom);
			t.mv = 16'($urandom);
			t.chg = 15'($urandom);
			t.dchg = 15'($urandom);
			t.fault = 1'($urandom);
			t.charging = 1'($urandom);
			t.otg = 1'($urandom);
			t.cmp_high = 1'($urandom);
			return t;
		end
		pick = $urandom_range(99);
		if (pick < 8)
			t.elapsed = 16'd0;
		else if (pick < 16)
			t.elapsed = 16'hFFFF;
		else if (pick < 30)
			t.elapsed = 16'($urandom);
		else
			t.elapsed = 16'($urandom_range(2000, 1));
		t.adc_valid = ($urandom_range(99) < 92);
		pick = $urandom_range(99);
		if (pick < 30) begin
			v = $urandom_range(600);
			v = v + int'(uv_cfg) - 300;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			t.mv = 16'(v);
		end else if (pick < 45) begin
			t.mv = 16'($urandom);
		end else begin
			t.mv = 16'($urandom_range(13000, 8500));
		end
		t.chg = random_ma();
		t.dchg = random_ma();
		t.charging = ($urandom_range(99) < (charge_trend ? 80 : 15));
		t.present = ($urandom_range(99) < 85);
		t.cmp_high = ($urandom_range(99) >= (uv_run ? 75 : 10));
		t.fault = ($urandom_range(99) < 5);
		t.otg = ($urandom_range(99) < 8);
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ticks_sent++;
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Unused upper data bits carry random values that the registers must drop.
	task automatic apply_config(input logic [14:0] cap, input logic [15:0] uv,
			input logic [15:0] deb);
		logic [31:0] word;
		word = $urandom;
		word[14:0] = cap;
		write_reg(bfg_pkg::REG_CAPACITY, word);
		word = $urandom;
		word[15:0] = uv;
		write_reg(bfg_pkg::REG_UV_MV, word);
		word = $urandom;
		word[15:0] = deb;
		write_reg(bfg_pkg::REG_DEBOUNCE, word);
		uv_cfg = uv;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int          phase;
		logic [15:0] seed_mv;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_gap_pct = 23;
		recv_stall_pct = 47;
		hold_off_now = 1'b0;
		charge_trend = 1'b0;
		uv_run = 1'b0;
		uv_cfg = bfg_pkg::UV_MV_RST;
		ticks_sent = 0;
		random_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed ticks on the reset settings; the seed is taken only once per reset.
		seed_mv = 16'($urandom_range(12599, 9001));
		send_tick(make_tick(16'd400, 1, 0, 16'd9000, 15'd500, 15'd0, 0, 1, 0, 0));
		send_tick(make_tick(16'd700, 1, 0, 16'd0, 15'd0, 15'd0, 0, 0, 0, 0));
		send_tick(make_tick(16'd0, 1, 1, seed_mv, 15'd0, 15'd0, 0, 0, 0, 1));
		send_tick(make_tick(16'hFFFF, 1, 1, 16'd12600, 15'h7FFF, 15'd0, 0, 1, 0, 1));
		send_tick(make_tick(16'hFFFF, 1, 1, 16'd12000, 15'd0, 15'h7FFF, 0, 1, 0, 1));
		repeat (6)
			send_tick(make_tick(16'hFFFF, 1, 1, 16'd11000, 15'd100, 15'h7FFF, 0, 0, 0, 1));
		send_tick(make_tick(16'd100, 1, 1, 16'd0, 15'd0, 15'd0, 0, 0, 0, 1));
		send_tick(make_tick(16'hFFFF, 1, 1, 16'hFFFF, 15'h7FFF, 15'h7FFF, 1, 1, 1, 1));
		send_tick(make_tick(16'd10, 1, 1, 16'd9601, 15'd0, 15'd0, 0, 0, 1, 1));
		send_tick(make_tick(16'd10, 0, 0, 16'd9000, 15'd0, 15'd0, 0, 0, 0, 0));
		send_tick(make_tick(16'd10, 1, 1, 16'd10000, 15'd0, 15'd0, 0, 0, 0, 1));
		send_tick(make_tick(16'd0, 1, 1, 16'd10000, 15'd0, 15'd5000, 0, 0, 0, 1));
		send_tick(make_tick(16'd0, 0, 0, 16'd0, 15'd0, 15'd0, 0, 0, 0, 0));
		send_tick(make_tick(16'd3599, 1, 1, 16'd11000, 15'd1, 15'd0, 0, 1, 0, 1));
		send_tick(make_tick(16'd3601, 1, 1, 16'd11000, 15'd0, 15'd1, 0, 0, 0, 1));
		send_tick(make_tick(16'd500, 0, 1, 16'd9600, 15'd0, 15'd0, 0, 0, 0, 1));
		send_tick(make_tick(16'd500, 0, 1, 16'd9601, 15'd0, 15'd0, 0, 0, 0, 1));

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_drained();
				case (phase)
					1: begin
						apply_config(15'd1, 16'd0, 16'd0);
						write_reg(REG_UNUSED, $urandom);
					end
					2: apply_config(15'h7FFF, 16'hFFFF, 16'hFFFF);
					3: apply_config(15'd0, 16'd10200, 16'd200);
					4: apply_config(15'd20000, 16'd11000, 16'd3000);
					default: apply_config(15'($urandom_range(20000, 1)),
						16'($urandom_range(12700, 8500)), 16'($urandom_range(5000)));
				endcase
			end
			if (phase == 4)
				hold_off_now = 1'b1;
			repeat (RANDOM_PER_PHASE) begin
				if (random_sent % 16 == 0) begin
					charge_trend = 1'($urandom_range(1));
					uv_run = ($urandom_range(3) == 0);
				end
				if (random_sent < IDLE_THIRD) begin
					send_gap_pct = 23;
					recv_stall_pct = 47;
				end else if (random_sent < 2 * IDLE_THIRD) begin
					send_gap_pct = 47;
					recv_stall_pct = 23;
				end else begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				send_tick(random_tick());
				random_sent++;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d poll ticks under %0d register settings, with idle gaps on both sides",
			ticks_sent, PHASES);
		$display("and a %0d-cycle receiver hold-off; %0d results compared, %0d clamped, %0d confirmed.",
			HOLD_OFF_CYCLES, checked, clamp_hits, uv_confirmations);
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (failures == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
